// ===== src/fcba_pkg.sv =====
// Package for the file-allocation-table block allocator.
// Holds request and status codes, field widths and the result record.
// Depends on nothing; the top level and fcba_ctrl import it.
package fcba_pkg;

    localparam int REQ_W  = 2;
    localparam int BLK_W  = 10;
    localparam int STAT_W = 2;
    localparam int REL_W  = 11;

    localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADV    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FOLLOW = 2'd2;
    localparam logic [REQ_W-1:0] REQ_FREE   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFREE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_END     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTUSED = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BLK_W-1:0]  result_block;
        logic [REL_W-1:0]  blocks_released;
    } fcba_res_t;

endpackage

// ===== src/fat_chain_block_allocator_unit.sv =====
// Top level of the file-allocation-table block allocator with its output register.
// Instantiates fcba_table and fcba_ctrl; depends on fcba_pkg.
//
//   channel | signals                                   | direction
//   in      | in_valid, in_stall, req_type, block_index | request transfer into the block
//   out     | out_valid, out_stall, status,             | one result transfer per request
//           | result_block, blocks_released             |
//
// After reset a clearing pass writes every table entry, with in_stall high.
// Requests are handled one at a time, as set by the single table read port.
// Follow and advance on a linked block read one table entry; allocate scans entries
// from the next-fit position (at most BLOCKS); extend reads the block, scans, then writes
// the link; free releases each block of the chain up to its end or a free block.
// A new request is taken while the previous result waits under out_stall.
module fat_chain_block_allocator_unit #(
    parameter int BLOCKS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [fcba_pkg::REQ_W-1:0]  req_type,
    input  logic [fcba_pkg::BLK_W-1:0]  block_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [fcba_pkg::STAT_W-1:0] status,
    output logic [fcba_pkg::BLK_W-1:0]  result_block,
    output logic [fcba_pkg::REL_W-1:0]  blocks_released
);
    import fcba_pkg::*;

    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W = $clog2(BLOCKS + 1);

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W+1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W+1:0] rd_data;
    logic             res_valid;
    logic             res_take;
    fcba_res_t        res;
    logic             out_valid_reg;
    fcba_res_t        out_reg;

    fcba_table #(
        .DEPTH (BLOCKS),
        .AW    (IDX_W),
        .DW    (IDX_W + 2)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fcba_ctrl #(
        .BLOCKS (BLOCKS),
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .block_index (block_index),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign result_block    = out_reg.result_block;
    assign blocks_released = out_reg.blocks_released;

    a_err_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> result_block == '0)
        else $error("Error status carries a nonzero block.");

    a_free_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && blocks_released != '0 |-> status == ST_OK && result_block == '0)
        else $error("Released count with a block or an error status.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Request transfer not followed by a busy cycle.");

    a_no_take_without_space: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |-> !out_valid || !out_stall)
        else $error("Result loaded over a stalled output transfer.");

endmodule

// ===== src/fcba_table.sv =====
// Link table storage: one synchronous memory, one write and one read port.
// Read data is registered and appears in the cycle after the read is issued. No dependencies.
module fcba_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 12
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/fcba_ctrl.sv =====
// Request sequencer: clearing pass, next-fit scan, link lookups and chain free walk.
// Drives the link table ports and hands one result record per request.
// Depends on fcba_pkg.
module fcba_ctrl #(
    parameter int BLOCKS = 1024,
    parameter int IDX_W  = 10,
    parameter int CNT_W  = 11
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [fcba_pkg::REQ_W-1:0] req_type,
    input  logic [fcba_pkg::BLK_W-1:0] block_index,
    output logic                       res_valid,
    input  logic                       res_take,
    output fcba_pkg::fcba_res_t        res,
    output logic                       wr_en,
    output logic [IDX_W-1:0]           wr_addr,
    output logic [IDX_W+1:0]           wr_data,
    output logic                       rd_en,
    output logic [IDX_W-1:0]           rd_addr,
    input  logic [IDX_W+1:0]           rd_data
);
    import fcba_pkg::*;

    localparam int CMP_W = IDX_W + 11;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(BLOCKS - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(BLOCKS);
    localparam logic [IDX_W+1:0] RST_ENT = {1'b0, 1'b1, {IDX_W{1'b0}}};
    localparam logic [IDX_W+1:0] NEW_ENT = {1'b1, 1'b1, {IDX_W{1'b0}}};

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_LINK  = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] srch_reg, srch_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             hit_reg, hit_next;
    logic [REQ_W-1:0] req_reg, req_next;
    logic [IDX_W-1:0] blk_reg, blk_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    fcba_res_t        res_reg, res_next;

    logic             in_range;
    logic [IDX_W-1:0] blk_addr;
    logic [IDX_W-1:0] pos_inc;
    logic [CNT_W-1:0] cnt_inc;
    logic [IDX_W+1:0] ent;
    logic             ent_used;
    logic             ent_end;
    logic [IDX_W-1:0] ent_link;

    assign in_range = CMP_W'(block_index) < CMP_W'(BLOCKS);
    assign blk_addr = IDX_W'(block_index);
    assign pos_inc  = (pos_reg == LAST) ? '0 : pos_reg + 1'b1;
    assign cnt_inc  = cnt_reg + 1'b1;

    // A read issued in the same cycle as a release of that block sees stale data.
    assign ent      = hit_reg ? RST_ENT : rd_data;
    assign ent_used = ent[IDX_W+1];
    assign ent_end  = ent[IDX_W];
    assign ent_link = ent[IDX_W-1:0];

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        srch_next  = srch_reg;
        cnt_next   = cnt_reg;
        hit_next   = hit_reg;
        req_next   = req_reg;
        blk_next   = blk_reg;
        cur_next   = cur_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = RST_ENT;
        rd_en      = 1'b0;
        rd_addr    = pos_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = pos_reg;
                wr_data  = RST_ENT;
                pos_next = pos_inc;
                if (pos_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = req_type;
                    blk_next = blk_addr;
                    cnt_next = '0;
                    hit_next = 1'b0;
                    res_next = '0;
                    priority if (req_type == REQ_ALLOC)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = srch_reg;
                        pos_next   = srch_reg;
                        state_next = S_SCAN;
                    end
                    else if (!in_range)
                    begin
                        res_next.status = ST_NOTUSED;
                        state_next      = S_DONE;
                    end
                    else if (req_type == REQ_FREE)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = blk_addr;
                        cur_next   = blk_addr;
                        state_next = S_FREE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = blk_addr;
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                priority if (!ent_used)
                begin
                    res_next.status = ST_NOTUSED;
                    state_next      = S_DONE;
                end
                else if (!ent_end)
                begin
                    res_next.result_block = BLK_W'(ent_link);
                    state_next            = S_DONE;
                end
                else if (req_reg == REQ_FOLLOW)
                begin
                    res_next.status = ST_END;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = srch_reg;
                    pos_next   = srch_reg;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (!rd_data[IDX_W+1])
                begin
                    wr_en                 = 1'b1;
                    wr_addr               = pos_reg;
                    wr_data               = NEW_ENT;
                    srch_next             = pos_inc;
                    res_next.result_block = BLK_W'(pos_reg);
                    state_next            = (req_reg == REQ_ADV) ? S_LINK : S_DONE;
                end
                else if (cnt_inc == FULL)
                begin
                    res_next.status = ST_NOFREE;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = pos_inc;
                    pos_next = pos_inc;
                    cnt_next = cnt_inc;
                end
            end
            S_LINK:
            begin
                wr_en      = 1'b1;
                wr_addr    = blk_reg;
                wr_data    = {1'b1, 1'b0, pos_reg};
                state_next = S_DONE;
            end
            S_FREE:
            begin
                priority if (!ent_used)
                begin
                    res_next.status          = (cnt_reg == '0) ? ST_NOTUSED : ST_OK;
                    res_next.blocks_released = REL_W'(cnt_reg);
                    state_next               = S_DONE;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = cur_reg;
                    wr_data  = RST_ENT;
                    cnt_next = cnt_inc;
                    if (ent_end || cnt_inc == FULL)
                    begin
                        res_next.blocks_released = REL_W'(cnt_inc);
                        state_next               = S_DONE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = ent_link;
                        cur_next = ent_link;
                        hit_next = (ent_link == cur_reg);
                    end
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pos_reg   <= '0;
            srch_reg  <= '0;
            cnt_reg   <= '0;
            hit_reg   <= 1'b0;
            req_reg   <= REQ_ALLOC;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            srch_reg  <= srch_next;
            cnt_reg   <= cnt_next;
            hit_reg   <= hit_next;
            req_reg   <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

endmodule
